[sv/mapp_pkg.sv]
// ----------------------------------------------------------------------------
// Marker arena pose projection package
// Shared widths, marker id codes, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package mapp_pkg;

    localparam int ID_W       = 10;
    localparam int POS_W      = 32;
    localparam int PIX_W      = 16;
    localparam int SIZE_W     = 31;
    localparam int HEAD_W     = 16;
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ID_W-1:0] ID_ORIGIN = 10'd0;
    localparam logic [ID_W-1:0] ID_XAXIS  = 10'd1;
    localparam logic [ID_W-1:0] ID_YAXIS  = 10'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ARENA_X_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARENA_Y_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] ARENA_X_SIZE_RST = 31'd131072;
    localparam logic [SIZE_W-1:0] ARENA_Y_SIZE_RST = 31'd65536;

    localparam int ATAN_STEPS = 24;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

    // atan(2^-i) in Q3.28.
    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/marker_arena_pose_projection.sv]
// ----------------------------------------------------------------------------
// Marker arena pose projection
// Projects tracked marker positions onto a reference arena frame and derives
// a heading from two marker corners, using one shared arithmetic datapath.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  one detected marker
//  m_*       out        m_tvalid/m_tready  arena position, heading, flag
//  cfg_*     in         cfg_wr_en          arena size registers
//
//  A reference marker (id 0, 1 or 2) is absorbed in the idle state and no
//  work follows. A tracked marker passes through the 20 shared products, the
//  bit-serial multiply and restoring divide of each axis (the divide ends early
//  when the quotient overflows), the two square roots, the two heading
//  multiplies, the normalizing shift and the 24 CORDIC steps; a degenerate
//  reference frame goes straight to the output. s_tready is low while
//  an item is in work and while a finished result waits for the output
//  register. Reset is synchronous; it clears the reference points and
//  restores the default arena sizes.
`default_nettype none

module marker_arena_pose_projection
    import mapp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // marker_id, pos_x, pos_y, pos_z, corner0_px_x, corner0_px_y,
    // corner1_px_x, corner1_px_y (lowest bit up), zero fill to 176 bits
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tracked_id, arena_x, arena_y, heading (lowest bit up), zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // degenerate
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SETUP, ST_PLOAD, ST_PMUL, ST_PDIV, ST_SLOAD, ST_SQRT,
        ST_HLOAD, ST_HMUL, ST_HCHK, ST_NORM, ST_CORDIC, ST_HFIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       phase_reg, phase_next;

    logic [SIZE_W-1:0] size_x_reg, size_x_next, size_y_reg, size_y_next;
    logic [POS_W-1:0]  ref_pos_reg [9], ref_pos_next [9];
    logic [PIX_W-1:0]  ref_pix_reg [6], ref_pix_next [6];

    logic [ID_W-1:0]     id_reg, id_next;
    logic signed [32:0]  md_reg [3], md_next [3];
    logic signed [32:0]  xd_reg [3], xd_next [3];
    logic signed [32:0]  yd_reg [3], yd_next [3];
    logic signed [16:0]  pd_reg [2], pd_next [2];
    logic signed [16:0]  qd_reg [2], qd_next [2];
    logic signed [16:0]  ed_reg [2], ed_next [2];

    logic signed [65:0]  prod_reg, prod_next;
    logic [4:0]          tag_reg, tag_next;
    logic signed [67:0]  sum_reg [8], sum_next [8];

    logic         deg_reg, deg_next;
    logic         neg_reg, neg_next;
    logic [99:0]  acc_reg, acc_next;
    logic [99:0]  mcand_reg, mcand_next;
    logic [30:0]  mplier_reg, mplier_next;
    logic [99:0]  dv_reg, dv_next;
    logic [32:0]  q_reg, q_next;
    logic [31:0]  arena_x_reg, arena_x_next, arena_y_reg, arena_y_next;

    logic [49:0]  sv_reg, sv_next, sr_reg, sr_next, sb_reg, sb_next;
    logic [24:0]  rp_reg, rp_next, rq_reg, rq_next;
    logic [59:0]  hx_reg, hx_next, hy_reg, hy_next;
    logic         hxneg_reg, hxneg_next, hyneg_reg, hyneg_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next, z_reg, z_next;
    logic [HEAD_W-1:0]  hd_reg, hd_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    // Input field views.
    logic [ID_W-1:0]   in_id;
    logic [POS_W-1:0]  in_pos [3];
    logic [PIX_W-1:0]  in_c0x, in_c0y, in_c1x, in_c1y;

    assign in_id     = s_tdata[9:0];
    assign in_pos[0] = s_tdata[41:10];
    assign in_pos[1] = s_tdata[73:42];
    assign in_pos[2] = s_tdata[105:74];
    assign in_c0x    = s_tdata[121:106];
    assign in_c0y    = s_tdata[137:122];
    assign in_c1x    = s_tdata[153:138];
    assign in_c1y    = s_tdata[169:154];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Shared multiplier operands and accumulator slot for each product.
    logic signed [32:0] opa, opb;
    logic [2:0]         slot;

    always_comb begin
        opa = '0;
        opb = '0;
        case (cnt_reg[4:0])
            5'd0:    begin opa = md_reg[0]; opb = xd_reg[0]; end
            5'd1:    begin opa = md_reg[1]; opb = xd_reg[1]; end
            5'd2:    begin opa = md_reg[2]; opb = xd_reg[2]; end
            5'd3:    begin opa = xd_reg[0]; opb = xd_reg[0]; end
            5'd4:    begin opa = xd_reg[1]; opb = xd_reg[1]; end
            5'd5:    begin opa = xd_reg[2]; opb = xd_reg[2]; end
            5'd6:    begin opa = md_reg[0]; opb = yd_reg[0]; end
            5'd7:    begin opa = md_reg[1]; opb = yd_reg[1]; end
            5'd8:    begin opa = md_reg[2]; opb = yd_reg[2]; end
            5'd9:    begin opa = yd_reg[0]; opb = yd_reg[0]; end
            5'd10:   begin opa = yd_reg[1]; opb = yd_reg[1]; end
            5'd11:   begin opa = yd_reg[2]; opb = yd_reg[2]; end
            5'd12:   begin opa = 33'(pd_reg[0]); opb = 33'(pd_reg[0]); end
            5'd13:   begin opa = 33'(pd_reg[1]); opb = 33'(pd_reg[1]); end
            5'd14:   begin opa = 33'(qd_reg[0]); opb = 33'(qd_reg[0]); end
            5'd15:   begin opa = 33'(qd_reg[1]); opb = 33'(qd_reg[1]); end
            5'd16:   begin opa = 33'(ed_reg[0]); opb = 33'(pd_reg[0]); end
            5'd17:   begin opa = 33'(ed_reg[1]); opb = 33'(pd_reg[1]); end
            5'd18:   begin opa = 33'(ed_reg[0]); opb = 33'(qd_reg[0]); end
            5'd19:   begin opa = 33'(ed_reg[1]); opb = 33'(qd_reg[1]); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // Slots: 0 num x, 1 den x, 2 num y, 3 den y, 4 |P|^2, 5 |Q|^2, 6 E.P, 7 E.Q
    always_comb begin
        case (tag_reg)
            5'd0, 5'd1, 5'd2:    slot = 3'd0;
            5'd3, 5'd4, 5'd5:    slot = 3'd1;
            5'd6, 5'd7, 5'd8:    slot = 3'd2;
            5'd9, 5'd10, 5'd11:  slot = 3'd3;
            5'd12, 5'd13:        slot = 3'd4;
            5'd14, 5'd15:        slot = 3'd5;
            5'd16, 5'd17:        slot = 3'd6;
            default:             slot = 3'd7;
        endcase
    end

    // Operand selection for the current axis or heading pass.
    logic signed [67:0] num_sel, den_sel, hd_sel;
    logic [67:0]        num_mag;
    logic [99:0]        den_wide;
    logic [30:0]        size_sel;
    logic               div_ge, div_ovf;
    logic [99:0]        acc_sum;
    logic [32:0]        q_fin;
    logic [31:0]        sat_val;
    logic [49:0]        sq_try;
    logic [4:0]         cord_i;
    logic signed [31:0] cx_sh, cy_sh, z_clamp, z_quad, r_full;

    assign num_sel  = phase_reg ? sum_reg[2] : sum_reg[0];
    assign den_sel  = phase_reg ? sum_reg[3] : sum_reg[1];
    assign hd_sel   = phase_reg ? sum_reg[6] : sum_reg[7];
    assign size_sel = phase_reg ? size_y_reg : size_x_reg;
    assign num_mag  = num_sel[67] ? 68'(-num_sel) : 68'(num_sel);
    assign den_wide = {32'b0, den_sel[67:0]};
    assign acc_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : 100'd0);
    assign div_ovf  = (acc_reg >= (den_wide << 32));
    assign div_ge   = (acc_reg >= dv_reg);
    assign q_fin    = div_ovf && (cnt_reg == 6'd0) ? 33'h100000000 : {q_reg[31:0], div_ge};
    assign sq_try   = sr_reg + sb_reg;
    assign cord_i   = cnt_reg[4:0];
    assign cx_sh    = cx_reg >>> cord_i;
    assign cy_sh    = cy_reg >>> cord_i;

    // Truncated quotient saturated to signed 32 bits.
    always_comb begin
        if (neg_reg) begin
            sat_val = (q_fin > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - q_fin);
        end else begin
            sat_val = (q_fin > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_fin[31:0];
        end
    end

    always_comb begin
        if (z_reg < 0) begin
            z_clamp = '0;
        end else if (z_reg > HALF_PI_Q28) begin
            z_clamp = HALF_PI_Q28;
        end else begin
            z_clamp = z_reg;
        end
        z_quad = hxneg_reg ? (PI_Q28 - z_clamp) : z_clamp;
        r_full = (z_quad + 32'sd16384) >>> 15;
        if (hyneg_reg) begin
            r_full = -r_full;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        size_x_next   = size_x_reg;
        size_y_next   = size_y_reg;
        ref_pos_next  = ref_pos_reg;
        ref_pix_next  = ref_pix_reg;
        id_next       = id_reg;
        md_next       = md_reg;
        xd_next       = xd_reg;
        yd_next       = yd_reg;
        pd_next       = pd_reg;
        qd_next       = qd_reg;
        ed_next       = ed_reg;
        prod_next     = prod_reg;
        tag_next      = tag_reg;
        sum_next      = sum_reg;
        deg_next      = deg_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        dv_next       = dv_reg;
        q_next        = q_reg;
        arena_x_next  = arena_x_reg;
        arena_y_next  = arena_y_reg;
        sv_next       = sv_reg;
        sr_next       = sr_reg;
        sb_next       = sb_reg;
        rp_next       = rp_reg;
        rq_next       = rq_reg;
        hx_next       = hx_reg;
        hy_next       = hy_reg;
        hxneg_next    = hxneg_reg;
        hyneg_next    = hyneg_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        z_next        = z_reg;
        hd_next       = hd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ARENA_X_SIZE: size_x_next = cfg_data;
                REG_ARENA_Y_SIZE: size_y_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_id == ID_ORIGIN || in_id == ID_XAXIS || in_id == ID_YAXIS) begin
                        for (int i = 0; i < 3; i++) begin
                            ref_pos_next[int'(in_id[1:0]) * 3 + i] = in_pos[i];
                        end
                        ref_pix_next[int'(in_id[1:0]) * 2]     = in_c0x;
                        ref_pix_next[int'(in_id[1:0]) * 2 + 1] = in_c0y;
                    end else begin
                        id_next = in_id;
                        for (int i = 0; i < 3; i++) begin
                            md_next[i] = 33'($signed(in_pos[i])) - 33'($signed(ref_pos_reg[i]));
                            xd_next[i] = 33'($signed(ref_pos_reg[3 + i]))
                                       - 33'($signed(ref_pos_reg[i]));
                            yd_next[i] = 33'($signed(ref_pos_reg[6 + i]))
                                       - 33'($signed(ref_pos_reg[i]));
                        end
                        for (int i = 0; i < 2; i++) begin
                            pd_next[i] = $signed({1'b0, ref_pix_reg[2 + i]})
                                       - $signed({1'b0, ref_pix_reg[i]});
                            qd_next[i] = $signed({1'b0, ref_pix_reg[4 + i]})
                                       - $signed({1'b0, ref_pix_reg[i]});
                        end
                        ed_next[0] = $signed({1'b0, in_c1x}) - $signed({1'b0, in_c0x});
                        ed_next[1] = $signed({1'b0, in_c1y}) - $signed({1'b0, in_c0y});
                        for (int i = 0; i < 8; i++) begin
                            sum_next[i] = '0;
                        end
                        deg_next   = 1'b0;
                        hd_next    = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end

            // Twenty products through the shared multiplier, each accumulated in the
            // cycle after it is formed.
            ST_MUL: begin
                if (cnt_reg < 6'd20) begin
                    prod_next = opa * opb;
                    tag_next  = cnt_reg[4:0];
                end
                if (cnt_reg != 6'd0) begin
                    sum_next[slot] = sum_reg[slot] + 68'(prod_reg);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd20) begin
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP: begin
                phase_next = 1'b0;
                if (sum_reg[1] == 0 || sum_reg[3] == 0 || sum_reg[4] == 0
                    || sum_reg[5] == 0) begin
                    deg_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PLOAD;
                end
            end

            ST_PLOAD: begin
                neg_next    = num_sel[67];
                mcand_next  = {32'b0, num_mag};
                mplier_next = size_sel;
                acc_next    = '0;
                q_next      = '0;
                cnt_next    = '0;
                state_next  = ST_PMUL;
            end

            ST_PMUL: begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd30) begin
                    cnt_next   = '0;
                    state_next = ST_PDIV;
                end
            end

            // Restoring divide of the scaled numerator by the squared length.
            ST_PDIV: begin
                if (cnt_reg == 6'd0 && !div_ovf) begin
                    dv_next  = den_wide << 31;
                    cnt_next = 6'd1;
                end else begin
                    if (cnt_reg != 6'd0) begin
                        if (div_ge) begin
                            acc_next = acc_reg - dv_reg;
                        end
                        q_next  = q_fin;
                        dv_next = dv_reg >> 1;
                    end
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0 || cnt_reg == 6'd32) begin
                        if (phase_reg) begin
                            arena_y_next = sat_val;
                            phase_next   = 1'b0;
                            state_next   = ST_SLOAD;
                        end else begin
                            arena_x_next = sat_val;
                            phase_next   = 1'b1;
                            state_next   = ST_PLOAD;
                        end
                    end
                end
            end

            ST_SLOAD: begin
                sv_next    = {phase_reg ? sum_reg[5][33:0] : sum_reg[4][33:0], 16'b0};
                sr_next    = '0;
                sb_next    = 50'd1 << 48;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end

            ST_SQRT: begin
                if (sv_reg >= sq_try) begin
                    sv_next = sv_reg - sq_try;
                    sr_next = (sr_reg >> 1) + sb_reg;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                sb_next  = sb_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd24) begin
                    if (phase_reg) begin
                        rq_next    = sr_next[24:0];
                        phase_next = 1'b0;
                        state_next = ST_HLOAD;
                    end else begin
                        rp_next    = sr_next[24:0];
                        phase_next = 1'b1;
                        state_next = ST_SLOAD;
                    end
                end
            end

            // Phase 0 forms (E.Q) * rP, phase 1 forms (E.P) * rQ, as magnitudes.
            ST_HLOAD: begin
                if (phase_reg) begin
                    hxneg_next  = hd_sel[67];
                    mplier_next = {6'b0, rq_reg};
                end else begin
                    hyneg_next  = hd_sel[67];
                    mplier_next = {6'b0, rp_reg};
                end
                mcand_next = hd_sel[67] ? 100'(-hd_sel) : 100'(hd_sel);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_HMUL;
            end

            ST_HMUL: begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd30) begin
                    if (phase_reg) begin
                        hx_next    = acc_sum[59:0];
                        state_next = ST_HCHK;
                    end else begin
                        hy_next    = acc_sum[59:0];
                        phase_next = 1'b1;
                        state_next = ST_HLOAD;
                    end
                end
            end

            ST_HCHK: begin
                if (hy_reg == '0) begin
                    z_next     = '0;
                    state_next = ST_HFIN;
                end else if (hx_reg == '0) begin
                    z_next     = HALF_PI_Q28;
                    state_next = ST_HFIN;
                end else begin
                    state_next = ST_NORM;
                end
            end

            // Halve both magnitudes until they fit the CORDIC range.
            ST_NORM: begin
                if ((hx_reg[59:29] | hy_reg[59:29]) != '0) begin
                    hx_next = hx_reg >> 1;
                    hy_next = hy_reg >> 1;
                end else begin
                    cx_next    = $signed({3'b0, hx_reg[28:0]});
                    cy_next    = $signed({3'b0, hy_reg[28:0]});
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end
            end

            ST_CORDIC: begin
                if (cy_reg > 0) begin
                    cx_next = cx_reg + cy_sh;
                    cy_next = cy_reg - cx_sh;
                    z_next  = z_reg + atan_q28(cord_i);
                end else begin
                    cx_next = cx_reg - cy_sh;
                    cy_next = cy_reg + cx_sh;
                    z_next  = z_reg - atan_q28(cord_i);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ATAN_STEPS - 1)) begin
                    state_next = ST_HFIN;
                end
            end

            ST_HFIN: begin
                hd_next    = r_full[HEAD_W-1:0];
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = deg_reg;
                    m_tdata_next  = {6'b0,
                                     deg_reg ? 16'd0 : hd_reg,
                                     deg_reg ? 32'd0 : arena_y_reg,
                                     deg_reg ? 32'd0 : arena_x_reg,
                                     id_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= 1'b0;
            size_x_reg   <= ARENA_X_SIZE_RST;
            size_y_reg   <= ARENA_Y_SIZE_RST;
            for (int i = 0; i < 9; i++) begin
                ref_pos_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                ref_pix_reg[i] <= '0;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            size_x_reg   <= size_x_next;
            size_y_reg   <= size_y_next;
            ref_pos_reg  <= ref_pos_next;
            ref_pix_reg  <= ref_pix_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        id_reg      <= id_next;
        md_reg      <= md_next;
        xd_reg      <= xd_next;
        yd_reg      <= yd_next;
        pd_reg      <= pd_next;
        qd_reg      <= qd_next;
        ed_reg      <= ed_next;
        prod_reg    <= prod_next;
        tag_reg     <= tag_next;
        sum_reg     <= sum_next;
        deg_reg     <= deg_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        dv_reg      <= dv_next;
        q_reg       <= q_next;
        arena_x_reg <= arena_x_next;
        arena_y_reg <= arena_y_next;
        sv_reg      <= sv_next;
        sr_reg      <= sr_next;
        sb_reg      <= sb_next;
        rp_reg      <= rp_next;
        rq_reg      <= rq_next;
        hx_reg      <= hx_next;
        hy_reg      <= hy_next;
        hxneg_reg   <= hxneg_next;
        hyneg_reg   <= hyneg_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        z_reg       <= z_next;
        hd_reg      <= hd_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

[sv/mapp_checker.sv]
// ----------------------------------------------------------------------------
// Marker arena pose projection port checker
// Watches the top-level ports for output stability and sequencing rules.
// ----------------------------------------------------------------------------
`default_nettype none

module mapp_checker
    import mapp_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready
);

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A tracked marker request keeps the input closed on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[9:0] != ID_ORIGIN && s_tdata[9:0] != ID_XAXIS
        && s_tdata[9:0] != ID_YAXIS |=> !s_tready)
        else $error("input accepted while a marker is in work");

    // A degenerate result carries zero position and heading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[89:10] == '0)
        else $error("degenerate result with nonzero values");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind marker_arena_pose_projection mapp_checker u_mapp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
